// ----- hdl/cmf_pkg.sv -----
// Shared widths, codes and stage records for the cube map face texel addresser.
// Used by the channel interfaces and by every module of the block.
// No dependencies.
package cmf_pkg;

	// Field widths.
	localparam int DIR_W      = 16;
	localparam int MAG_W      = 16;
	localparam int SUM_W      = 17;
	localparam int DEN_W      = 17;
	localparam int SIZE_W     = 13;
	localparam int CNT_W      = 3;
	localparam int FETCH_W    = 2;
	localparam int FACE_W     = 3;
	localparam int COORD_W    = 12;
	localparam int QUOT_W     = 13;
	localparam int NUM_W      = SIZE_W + SUM_W;
	localparam int PROD_W     = COORD_W + SIZE_W;
	localparam int OFS_W      = 26;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	// Largest face size the block addresses; larger writes are clamped.
	localparam int MAX_FACE_SIZE = 4096;

	// Reset values of the configuration registers.
	localparam logic [SIZE_W-1:0] SIZE_RESET   = SIZE_W'(512);
	localparam logic [CNT_W-1:0]  STRIDE_RESET = CNT_W'(3);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FACE_SIZE     = 1'b0,
		REG_CHANNEL_COUNT = 1'b1
	} cfg_reg_t;

	// Cube faces.
	typedef enum logic [FACE_W-1:0] {
		FACE_POS_X = 3'd0,
		FACE_NEG_X = 3'd1,
		FACE_POS_Y = 3'd2,
		FACE_NEG_Y = 3'd3,
		FACE_POS_Z = 3'd4,
		FACE_NEG_Z = 3'd5
	} face_t;

	// Channels to fetch.
	localparam logic [FETCH_W-1:0] FETCH_NONE  = 2'd0;
	localparam logic [FETCH_W-1:0] FETCH_ONE   = 2'd1;
	localparam logic [FETCH_W-1:0] FETCH_THREE = 2'd3;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic [SIZE_W-1:0]  size;
		logic [CNT_W-1:0]   stride;
		logic [FETCH_W-1:0] fetch;
	} cfg_t;

	// Face selection result.
	typedef struct packed {
		face_t              face;
		logic [MAG_W-1:0]   mag;
		logic [SUM_W-1:0]   sum_u;
		logic [SUM_W-1:0]   sum_v;
	} sel_t;

	// Division step record: shared divisor, two remainders, two quotients.
	typedef struct packed {
		face_t              face;
		logic [DEN_W-1:0]   den;
		logic [NUM_W-1:0]   rem_u;
		logic [NUM_W-1:0]   rem_v;
		logic [QUOT_W-1:0]  q_u;
		logic [QUOT_W-1:0]  q_v;
	} div_t;

	// Saturated coordinates and the row base product.
	typedef struct packed {
		face_t              face;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [PROD_W-1:0]  prod;
	} addr_t;

endpackage

// ----- hdl/cmf_if.sv -----
// Valid/ready channels of the cube map face texel addresser: direction words in,
// texel address words out, and configuration writes. Depends on cmf_pkg.

interface cmf_dir_if;
	import cmf_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [DIR_W-1:0] dir_x;
	logic signed [DIR_W-1:0] dir_y;
	logic signed [DIR_W-1:0] dir_z;
	modport source(output valid, output dir_x, output dir_y, output dir_z, input ready);
	modport sink(input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface cmf_tex_if;
	import cmf_pkg::*;
	logic               valid;
	logic               ready;
	logic [FACE_W-1:0]  face;
	logic [COORD_W-1:0] row;
	logic [COORD_W-1:0] column;
	logic [OFS_W-1:0]   element_offset;
	logic [FETCH_W-1:0] fetch_channels;
	modport source(output valid, output face, output row, output column,
		output element_offset, output fetch_channels, input ready);
	modport sink(input valid, input face, input row, input column,
		input element_offset, input fetch_channels, output ready);
endinterface

interface cmf_cfg_if;
	import cmf_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ----- hdl/cmf_cfg.sv -----
// Configuration registers: face size and channel count, kept in clamped form
// together with the fetch code. Depends on cmf_pkg and cmf_if.
module cmf_cfg (
	input  logic           clk,
	input  logic           arst_n,
	cmf_cfg_if.sink        cfg,
	output cmf_pkg::cfg_t  cfg_out
);
	import cmf_pkg::*;

	logic [SIZE_W-1:0]  size_q, size_new;
	logic [CNT_W-1:0]   stride_q, stride_new, cnt;
	logic [FETCH_W-1:0] fetch_q, fetch_new;

	// Writes are always taken.
	assign cfg.ready = 1'b1;
	assign cnt       = cfg.data[CNT_W-1:0];

	// Clamp the face size and the stride, and decode the fetch count.
	always_comb begin
		size_new = cfg.data[SIZE_W-1:0];
		if (size_new == '0) begin
			size_new = SIZE_W'(1);
		end else if (int'(size_new) > MAX_FACE_SIZE) begin
			size_new = SIZE_W'(MAX_FACE_SIZE);
		end
		stride_new = cnt;
		if (cnt == '0) begin
			stride_new = CNT_W'(1);
		end else if (cnt > CNT_W'(4)) begin
			stride_new = CNT_W'(4);
		end
		unique case (cnt)
			CNT_W'(1): fetch_new = FETCH_ONE;
			CNT_W'(3), CNT_W'(4): fetch_new = FETCH_THREE;
			default: fetch_new = FETCH_NONE;
		endcase
	end

	// Register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= SIZE_RESET;
			stride_q <= STRIDE_RESET;
			fetch_q  <= FETCH_THREE;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_FACE_SIZE: begin
					size_q <= size_new;
				end
				REG_CHANNEL_COUNT: begin
					stride_q <= stride_new;
					fetch_q  <= fetch_new;
				end
			endcase
		end
	end

	assign cfg_out.size   = size_q;
	assign cfg_out.stride = stride_q;
	assign cfg_out.fetch  = fetch_q;

endmodule

// ----- hdl/cmf_front.sv -----
// Front end: picks the major axis and face, forms the two projected sums, then
// scales them by the face size to make the dividends. Depends on cmf_pkg.
module cmf_front (
	input  logic                               clk,
	input  logic [1:0]                         en,
	input  logic signed [cmf_pkg::DIR_W-1:0]   dir_x,
	input  logic signed [cmf_pkg::DIR_W-1:0]   dir_y,
	input  logic signed [cmf_pkg::DIR_W-1:0]   dir_z,
	input  logic [cmf_pkg::SIZE_W-1:0]         size,
	output cmf_pkg::div_t                      num_out
);
	import cmf_pkg::*;

	logic signed [DIR_W:0]   xe, ye, ze;
	logic [MAG_W-1:0]        ax, ay, az, a;
	logic signed [DIR_W-1:0] mu, mv;
	logic                    pu, pv;
	face_t                   face;
	logic signed [DIR_W+1:0] ae, mue, mve, tu, tv;
	logic [NUM_W-1:0]        nu, nv;
	sel_t                    sel, sel_s1;
	div_t                    num_s2;

	// Magnitudes; the most negative code becomes 2^15.
	assign xe = {dir_x[DIR_W-1], dir_x};
	assign ye = {dir_y[DIR_W-1], dir_y};
	assign ze = {dir_z[DIR_W-1], dir_z};
	assign ax = xe[DIR_W] ? MAG_W'(-xe) : MAG_W'(xe);
	assign ay = ye[DIR_W] ? MAG_W'(-ye) : MAG_W'(ye);
	assign az = ze[DIR_W] ? MAG_W'(-ze) : MAG_W'(ze);

	// Face choice: ties go to x, then y. The all-zero vector uses a unit
	// magnitude (a divisor of 2) and unit sums, which lands on the face center.
	always_comb begin
		face = FACE_POS_X;
		a    = MAG_W'(1);
		mu   = '0;
		mv   = '0;
		pu   = 1'b1;
		pv   = 1'b1;
		priority if (ax == '0 && ay == '0 && az == '0) begin
			face = FACE_POS_X;
		end else if (ax >= ay && ax >= az) begin
			a    = ax;
			face = dir_x[DIR_W-1] ? FACE_NEG_X : FACE_POS_X;
			mu   = dir_z;
			pu   = dir_x[DIR_W-1];
			mv   = dir_y;
			pv   = 1'b0;
		end else if (ay >= az) begin
			a    = ay;
			face = dir_y[DIR_W-1] ? FACE_NEG_Y : FACE_POS_Y;
			mu   = dir_x;
			pu   = 1'b1;
			mv   = dir_z;
			pv   = !dir_y[DIR_W-1];
		end else begin
			a    = az;
			face = dir_z[DIR_W-1] ? FACE_NEG_Z : FACE_POS_Z;
			mu   = dir_x;
			pu   = !dir_z[DIR_W-1];
			mv   = dir_y;
			pv   = 1'b0;
		end
	end

	// Sums |M| +/- minor, never negative since the minor is not larger.
	assign ae  = $signed({2'b00, a});
	assign mue = {{2{mu[DIR_W-1]}}, mu};
	assign mve = {{2{mv[DIR_W-1]}}, mv};
	assign tu  = pu ? ae + mue : ae - mue;
	assign tv  = pv ? ae + mve : ae - mve;

	assign sel.face  = face;
	assign sel.mag   = a;
	assign sel.sum_u = SUM_W'(tu);
	assign sel.sum_v = SUM_W'(tv);

	// Stage 1 register.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			sel_s1 <= sel;
		end
	end

	// Dividends: face size times each sum.
	assign nu = {{(NUM_W-SUM_W){1'b0}}, sel_s1.sum_u} * {{(NUM_W-SIZE_W){1'b0}}, size};
	assign nv = {{(NUM_W-SUM_W){1'b0}}, sel_s1.sum_v} * {{(NUM_W-SIZE_W){1'b0}}, size};

	// Stage 2 register; the divisor is twice the major magnitude.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			num_s2.face  <= sel_s1.face;
			num_s2.den   <= {sel_s1.mag, 1'b0};
			num_s2.rem_u <= nu;
			num_s2.rem_v <= nv;
			num_s2.q_u   <= '0;
			num_s2.q_v   <= '0;
		end
	end

	assign num_out = num_s2;

endmodule

// ----- hdl/cmf_div.sv -----
// Pipelined restoring divider: one quotient bit per stage for both coordinates,
// which share one divisor. Depends on cmf_pkg.
module cmf_div (
	input  logic                        clk,
	input  logic [cmf_pkg::QUOT_W-1:0]  en,
	input  cmf_pkg::div_t               din,
	output cmf_pkg::div_t               dout
);
	import cmf_pkg::*;

	div_t stg_s [QUOT_W];

	// Stage j settles quotient bit QUOT_W-1-j, most significant first.
	for (genvar j = 0; j < QUOT_W; j++) begin : g_step
		localparam int B = QUOT_W - 1 - j;
		div_t             cur, nxt;
		logic [NUM_W-1:0] trial;

		if (j == 0) begin : g_first
			assign cur = din;
		end else begin : g_next
			assign cur = stg_s[j-1];
		end

		assign trial = {{(NUM_W-DEN_W){1'b0}}, cur.den} << B;

		// Trial subtraction on both remainders.
		always_comb begin
			nxt = cur;
			if (cur.rem_u >= trial) begin
				nxt.rem_u  = cur.rem_u - trial;
				nxt.q_u[B] = 1'b1;
			end
			if (cur.rem_v >= trial) begin
				nxt.rem_v  = cur.rem_v - trial;
				nxt.q_v[B] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				stg_s[j] <= nxt;
			end
		end
	end

	assign dout = stg_s[QUOT_W-1];

endmodule

// ----- hdl/cmf_addr.sv -----
// Back end: saturates the quotients to the face, then forms the element offset
// (row*size+column)*stride. Depends on cmf_pkg.
module cmf_addr (
	input  logic                          clk,
	input  logic [1:0]                    en,
	input  cmf_pkg::div_t                 din,
	input  cmf_pkg::cfg_t                 cfg,
	output logic [cmf_pkg::FACE_W-1:0]    face,
	output logic [cmf_pkg::COORD_W-1:0]   row,
	output logic [cmf_pkg::COORD_W-1:0]   column,
	output logic [cmf_pkg::OFS_W-1:0]     element_offset,
	output logic [cmf_pkg::FETCH_W-1:0]   fetch_channels
);
	import cmf_pkg::*;

	logic [SIZE_W-1:0]  lim;
	logic [QUOT_W-1:0]  su, sv;
	logic [COORD_W-1:0] ru;
	logic [PROD_W-1:0]  base;
	logic [PROD_W-1:0]  lin;
	logic [OFS_W-1:0]   ofs;
	addr_t              sat_s16;
	face_t              face_s17;
	logic [COORD_W-1:0] row_s17, col_s17;
	logic [OFS_W-1:0]   ofs_s17;
	logic [FETCH_W-1:0] fetch_s17;

	// A coordinate that reaches the face size falls back to its last texel.
	assign lim  = cfg.size - SIZE_W'(1);
	assign su   = (din.q_u > lim) ? lim : din.q_u;
	assign sv   = (din.q_v > lim) ? lim : din.q_v;
	assign ru   = COORD_W'(su);
	assign base = {{(PROD_W-COORD_W){1'b0}}, ru} * {{(PROD_W-SIZE_W){1'b0}}, cfg.size};

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sat_s16.face <= din.face;
			sat_s16.row  <= ru;
			sat_s16.col  <= COORD_W'(sv);
			sat_s16.prod <= base;
		end
	end

	// Add the column and scale by the channel stride.
	assign lin = sat_s16.prod + {{(PROD_W-COORD_W){1'b0}}, sat_s16.col};
	assign ofs = {{(OFS_W-PROD_W){1'b0}}, lin} * {{(OFS_W-CNT_W){1'b0}}, cfg.stride};

	always_ff @(posedge clk) begin
		if (en[1]) begin
			face_s17  <= sat_s16.face;
			row_s17   <= sat_s16.row;
			col_s17   <= sat_s16.col;
			ofs_s17   <= ofs;
			fetch_s17 <= cfg.fetch;
		end
	end

	assign face           = face_s17;
	assign row            = row_s17;
	assign column         = col_s17;
	assign element_offset = ofs_s17;
	assign fetch_channels = fetch_s17;

endmodule

// ----- hdl/cube_map_face_texel_address_top.sv -----
// Cube map face selection and texel addressing, top level.
// Channels: dir takes one direction word (dir_x, dir_y, dir_z, signed Q1.15);
// texel returns one word per direction: face 0..5, row, column, the element
// offset (row*size+column)*channels and the number of channels to fetch.
// cfg writes registers: index 0 is the face size, index 1 the channel count.
// Write cfg only while no direction word is in flight; writes are always taken.
// Path from an accepted direction to its texel word: two front stages (face
// choice, then dividend multiply), 13 divider stages (one quotient bit each)
// and two address stages. With texel.ready high, one word per cycle is sustained.
// Each stage holds a valid bit and advances when the stage after it is empty
// or moving, so a stalled receiver holds its word while empty stages upstream
// keep filling; dir.ready falls only once the whole pipeline is full.
// Reset empties the pipeline and sets face size 512 and channel count 3.
// Depends on cmf_pkg, cmf_if, cmf_cfg, cmf_front, cmf_div and cmf_addr.
module cube_map_face_texel_address_top (
	input  logic     clk,
	input  logic     arst_n,
	cmf_cfg_if.sink  cfg,
	cmf_dir_if.sink  dir,
	cmf_tex_if.source texel
);
	import cmf_pkg::*;

	localparam int NSTG = 2 + QUOT_W + 2;

	logic [NSTG-1:0] vld_q, en;
	cfg_t            cfg_cur;
	div_t            num, quot;

	// Stage enables: a stage loads when it is empty or its word moves on.
	always_comb begin
		en[NSTG-1] = !vld_q[NSTG-1] || texel.ready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= dir.valid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign dir.ready   = en[0];
	assign texel.valid = vld_q[NSTG-1];

	cmf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_out (cfg_cur)
	);

	cmf_front u_front (
		.clk     (clk),
		.en      (en[1:0]),
		.dir_x   (dir.dir_x),
		.dir_y   (dir.dir_y),
		.dir_z   (dir.dir_z),
		.size    (cfg_cur.size),
		.num_out (num)
	);

	cmf_div u_div (
		.clk  (clk),
		.en   (en[QUOT_W+1:2]),
		.din  (num),
		.dout (quot)
	);

	cmf_addr u_addr (
		.clk            (clk),
		.en             (en[NSTG-1:NSTG-2]),
		.din            (quot),
		.cfg            (cfg_cur),
		.face           (texel.face),
		.row            (texel.row),
		.column         (texel.column),
		.element_offset (texel.element_offset),
		.fetch_channels (texel.fetch_channels)
	);

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the cube map face texel addresser: corner and random directions
// under many face sizes and channel counts, with random stalls on both channels.
// Depends on cmf_pkg, the cmf channel interfaces and cube_map_face_texel_address_top.
module tb_top;
	import cmf_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_STALL  = 80;
	localparam int PHASE_ITEMS = 90;
	localparam int SETTLE      = 40;

	typedef struct {
		logic signed [DIR_W-1:0] x;
		logic signed [DIR_W-1:0] y;
		logic signed [DIR_W-1:0] z;
	} dir_word_t;

	typedef struct {
		face_t              face;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] column;
		logic [OFS_W-1:0]   offset;
		logic [FETCH_W-1:0] fetch;
	} texel_word_t;

	logic clk;
	logic arst_n;

	cmf_cfg_if cfg_bus();
	cmf_dir_if dir_bus();
	cmf_tex_if texel_bus();

	cube_map_face_texel_address_top DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_bus),
		.dir   (dir_bus),
		.texel (texel_bus)
	);

	// Bench copy of the two registers.
	logic [SIZE_W-1:0] face_size_reg;
	logic [CNT_W-1:0]  channel_count_reg;

	dir_word_t   dir_pending[$];
	texel_word_t texels_due[$];
	dir_word_t   dir_now;
	texel_word_t texel_want;

	bit dir_busy;
	bit dir_taken;
	bit texel_taken;
	int src_gap;
	int src_gap_max;
	int sink_hold;
	int sink_gap_max;
	int long_stalls_asked;
	int long_stalls_done;
	int cycle_count;
	int words_checked;
	int mismatch_count;
	int settings_run;

	// Clock, 20 ns period.
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// One face coordinate: floor(S*(a +/- m)/(2a)), saturated to S-1.
	function automatic longint face_coord(longint s, longint a, bit plus, longint m);
		longint sum;
		longint q;
		sum = plus ? a + m : a - m;
		if (sum < 0)
			sum = 0;
		q = (s * sum) / (2 * a);
		if (q > s - 1)
			q = s - 1;
		return q;
	endfunction

	// Texel word expected for one direction under the given register values.
	function automatic texel_word_t predict_texel(dir_word_t d, logic [SIZE_W-1:0] size_cfg,
			logic [CNT_W-1:0] count_cfg);
		longint x;
		longint y;
		longint z;
		longint ax;
		longint ay;
		longint az;
		longint s;
		longint stride;
		longint u;
		longint v;
		texel_word_t w;
		x = d.x;
		y = d.y;
		z = d.z;
		ax = x < 0 ? -x : x;
		ay = y < 0 ? -y : y;
		az = z < 0 ? -z : z;
		s = size_cfg;
		if (s < 1)
			s = 1;
		if (s > MAX_FACE_SIZE)
			s = MAX_FACE_SIZE;
		stride = count_cfg;
		if (stride < 1)
			stride = 1;
		if (stride > 4)
			stride = 4;

		// Largest magnitude picks the face; ties go to x, then to y.
		if (ax == 0 && ay == 0 && az == 0) begin
			w.face = FACE_POS_X;
			u = s / 2;
			if (u > s - 1)
				u = s - 1;
			v = u;
		end else if (ax >= ay && ax >= az) begin
			if (x > 0) begin
				w.face = FACE_POS_X;
				u = face_coord(s, ax, 1'b0, z);
			end else begin
				w.face = FACE_NEG_X;
				u = face_coord(s, ax, 1'b1, z);
			end
			v = face_coord(s, ax, 1'b0, y);
		end else if (ay >= az) begin
			u = face_coord(s, ay, 1'b1, x);
			if (y > 0) begin
				w.face = FACE_POS_Y;
				v = face_coord(s, ay, 1'b1, z);
			end else begin
				w.face = FACE_NEG_Y;
				v = face_coord(s, ay, 1'b0, z);
			end
		end else begin
			if (z > 0) begin
				w.face = FACE_POS_Z;
				u = face_coord(s, az, 1'b1, x);
			end else begin
				w.face = FACE_NEG_Z;
				u = face_coord(s, az, 1'b0, x);
			end
			v = face_coord(s, az, 1'b0, y);
		end

		w.row    = COORD_W'(u);
		w.column = COORD_W'(v);
		w.offset = OFS_W'((u * s + v) * stride);
		if (count_cfg == 1)
			w.fetch = FETCH_ONE;
		else if (count_cfg == 3 || count_cfg == 4)
			w.fetch = FETCH_THREE;
		else
			w.fetch = FETCH_NONE;
		return w;
	endfunction

	// One random component, biased toward zero and the range ends.
	function automatic logic signed [DIR_W-1:0] rand_comp();
		case ($urandom_range(0, 9))
			0: return '0;
			1: begin
				case ($urandom_range(0, 4))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return 16'sh8001;
					3: return 16'sh0001;
					default: return 16'shFFFF;
				endcase
			end
			default: return DIR_W'($urandom);
		endcase
	endfunction

	task automatic push_dir(int x, int y, int z);
		dir_word_t d;
		d.x = DIR_W'(x);
		d.y = DIR_W'(y);
		d.z = DIR_W'(z);
		dir_pending = {dir_pending, d};
	endtask

	task automatic push_random();
		dir_word_t d;
		d.x = rand_comp();
		d.y = rand_comp();
		d.z = rand_comp();
		// Equal magnitudes exercise the tie rules.
		case ($urandom_range(0, 7))
			0: d.y = $urandom_range(0, 1) ? d.x : -d.x;
			1: d.z = $urandom_range(0, 1) ? d.y : -d.y;
			2: d.z = $urandom_range(0, 1) ? d.x : -d.x;
			3: begin
				d.y = d.x;
				d.z = -d.x;
			end
			default: ;
		endcase
		dir_pending = {dir_pending, d};
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatch_count++;
		$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// Register write, driven at the falling edge and taken at a rising edge.
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		case (idx)
			REG_FACE_SIZE:     face_size_reg = value[SIZE_W-1:0];
			REG_CHANNEL_COUNT: channel_count_reg = value[CNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// Waits until every direction has gone in and every texel word has come back.
	task automatic drain();
		while (dir_pending.size() != 0 || dir_busy || texels_due.size() != 0)
			@(posedge clk);
	endtask

	// One register setting: drain, write, then a batch of random directions.
	task automatic run_phase(bit write_regs, int size, int count, int src_max,
			int sink_max, bit long_stall);
		logic [CFG_DATA_W-1:0] count_word;
		drain();
		if (write_regs) begin
			write_reg(REG_FACE_SIZE, CFG_DATA_W'(size));
			// Upper data bits carry noise; only the low bits reach the register.
			count_word = CFG_DATA_W'($urandom);
			count_word[CNT_W-1:0] = CNT_W'(count);
			write_reg(REG_CHANNEL_COUNT, count_word);
		end
		src_gap_max  = src_max;
		sink_gap_max = sink_max;
		settings_run++;
		if (long_stall)
			long_stalls_asked++;
		repeat (PHASE_ITEMS)
			push_random();
	endtask

	// Direction driver: takes the next pending word after a random gap.
	always @(negedge clk) begin
		if (dir_taken) begin
			dir_taken = 1'b0;
			dir_busy  = 1'b0;
			src_gap   = $urandom_range(0, src_gap_max);
		end
		if (arst_n && !dir_busy) begin
			if (src_gap > 0)
				src_gap--;
			else if (dir_pending.size() > 0) begin
				dir_now  = dir_pending.pop_front();
				dir_busy = 1'b1;
			end
		end
		dir_bus.valid <= dir_busy;
		dir_bus.dir_x <= dir_now.x;
		dir_bus.dir_y <= dir_now.y;
		dir_bus.dir_z <= dir_now.z;
	end

	// An accepted direction adds its expected texel word.
	always @(posedge clk) begin
		if (dir_bus.valid && dir_bus.ready) begin
			texels_due = {texels_due,
				predict_texel(dir_now, face_size_reg, channel_count_reg)};
			dir_taken = 1'b1;
		end
	end

	// Receiver ready: random stall per word, plus the long hold-offs asked for.
	always @(negedge clk) begin
		if (texel_taken) begin
			texel_taken = 1'b0;
			sink_hold   = $urandom_range(0, sink_gap_max);
		end
		if (long_stalls_done < long_stalls_asked && sink_hold == 0) begin
			sink_hold = LONG_STALL;
			long_stalls_done++;
		end
		if (!arst_n)
			texel_bus.ready <= 1'b0;
		else if (sink_hold > 0) begin
			sink_hold--;
			texel_bus.ready <= 1'b0;
		end else
			texel_bus.ready <= 1'b1;
	end

	// Monitor: each accepted texel word against the oldest expectation.
	always @(posedge clk) begin
		if (texel_bus.valid && texel_bus.ready) begin
			texel_taken = 1'b1;
			if (texels_due.size() == 0)
				report_mismatch("texel word with none due", texel_bus.face, 0);
			else begin
				texel_want = texels_due.pop_front();
				words_checked++;
				if (texel_bus.face !== texel_want.face)
					report_mismatch("face", texel_bus.face, texel_want.face);
				if (texel_bus.row !== texel_want.row)
					report_mismatch("row", texel_bus.row, texel_want.row);
				if (texel_bus.column !== texel_want.column)
					report_mismatch("column", texel_bus.column, texel_want.column);
				if (texel_bus.element_offset !== texel_want.offset)
					report_mismatch("element_offset", texel_bus.element_offset,
						texel_want.offset);
				if (texel_bus.fetch_channels !== texel_want.fetch)
					report_mismatch("fetch_channels", texel_bus.fetch_channels,
						texel_want.fetch);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still due", cycle_count,
				texels_due.size());
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n            = 1'b0;
		cfg_bus.valid     = 1'b0;
		cfg_bus.index     = REG_FACE_SIZE;
		cfg_bus.data      = '0;
		dir_bus.valid     = 1'b0;
		dir_bus.dir_x     = '0;
		dir_bus.dir_y     = '0;
		dir_bus.dir_z     = '0;
		texel_bus.ready   = 1'b0;
		face_size_reg     = SIZE_RESET;
		channel_count_reg = STRIDE_RESET;
		dir_now           = '{default: '0};
		dir_busy          = 1'b0;
		dir_taken         = 1'b0;
		texel_taken       = 1'b0;
		src_gap           = 0;
		sink_hold         = 0;
		src_gap_max       = 9;
		sink_gap_max      = 9;
		long_stalls_asked = 0;
		long_stalls_done  = 0;
		cycle_count       = 0;
		words_checked     = 0;
		mismatch_count    = 0;
		settings_run      = 0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Corner directions under the reset settings: the zero vector, axis
		// extremes, every face, ties between axes and edge overflow.
		push_dir(0, 0, 0);
		push_dir(32767, 0, 0);
		push_dir(-32768, 0, 0);
		push_dir(0, 32767, 0);
		push_dir(0, -32768, 0);
		push_dir(0, 0, 32767);
		push_dir(0, 0, -32768);
		push_dir(-32768, 32767, 32767);
		push_dir(1000, -1000, -1000);
		push_dir(-1000, 1000, 1000);
		push_dir(-32768, -32768, -32768);
		push_dir(5, 5, 3);
		push_dir(3, -7, 7);
		push_dir(0, 1, -1);
		push_dir(-1, 0, 1);
		push_dir(1, 0, 0);
		push_dir(0, -1, 0);
		push_dir(0, 0, 1);
		push_dir(32767, -32768, 0);
		push_dir(100, 20000, -32767);
		push_dir(12345, -23456, 30000);
		push_dir(23170, 23170, 0);
		push_dir(-16384, 28377, 0);

		// Random batches; sizes 0 and 8191 check clamping, counts cover 0..7.
		run_phase(1'b0, 512, 3, 9, 9, 1'b1);
		run_phase(1'b1, 1, 1, 0, 0, 1'b0);
		run_phase(1'b1, 4096, 4, 0, 9, 1'b1);
		run_phase(1'b1, 8191, 0, 9, 0, 1'b0);
		run_phase(1'b1, 0, 7, 9, 9, 1'b0);
		run_phase(1'b1, 2, 2, 3, 3, 1'b0);
		run_phase(1'b1, 3, 5, 0, 0, 1'b0);
		run_phase(1'b1, 4095, 6, 9, 9, 1'b0);
		run_phase(1'b1, 4096, 3, 0, 9, 1'b1);
		run_phase(1'b1, $urandom_range(1, 4096), $urandom_range(0, 7), 9, 9, 1'b0);
		run_phase(1'b1, 7, 1, 5, 2, 1'b0);
		run_phase(1'b1, 512, 3, 2, 5, 1'b0);

		drain();
		repeat (SETTLE) @(posedge clk);

		$display("Checked %0d texel words over %0d register settings, face sizes 1 to 4096,",
			words_checked, settings_run);
		$display("channel counts 0 to 7, %0d long receiver hold-offs, %0d mismatches.",
			long_stalls_done, mismatch_count);
		if (mismatch_count == 0 && texels_due.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
